// ----- design/mrpt_pkg.sv -----
package mrpt_pkg;

  localparam int WIDTH = 64;
  localparam int CW = $clog2(WIDTH);
  localparam int SW = CW + 1;
  localparam int NBASE = 7;
  localparam int KW = $clog2(NBASE);

  typedef logic [WIDTH-1:0] word_t;

  function automatic word_t base_at(input logic [KW-1:0] k);
    word_t v;
    unique case (k)
      3'd0: v = word_t'(2);
      3'd1: v = word_t'(325);
      3'd2: v = word_t'(9375);
      3'd3: v = word_t'(28178);
      3'd4: v = word_t'(450775);
      3'd5: v = word_t'(9780504);
      3'd6: v = word_t'(1795265022);
      default: v = '0;
    endcase
    return v;
  endfunction

  // (x + y) mod m for x, y < m
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
    word_t gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  typedef enum logic [1:0] {
    MM_RED,
    MM_MUL,
    MM_SQB,
    MM_SQX
  } mm_op_t;

  typedef struct packed {
    logic            load;
    logic            shift_d;
    logic            pow_init;
    logic            e_shift;
    logic            r_init;
    logic            r_inc;
    logic            mm_start;
    mm_op_t          mm_op;
    logic [KW-1:0]   base_idx;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_eq2;
    logic n_even;
    logic d_odd;
    logic base_eq_n;
    logic a_zero;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic r_lt_s;
    logic mm_done;
  } status_t;

endpackage

// ----- design/mrpt_mulmod.sv -----
module mrpt_mulmod (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mrpt_pkg::word_t x,
  input  mrpt_pkg::word_t y,
  input  mrpt_pkg::word_t m,
  output logic           done,
  output mrpt_pkg::word_t result
);
  import mrpt_pkg::*;

  word_t acc, xs, ys, ms;
  logic [CW-1:0] cnt;
  logic phase, busy;

  // Interleaved shift-and-add: one doubling and one conditional add per bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CW'(WIDTH - 1);
        acc   <= '0;
        xs    <= x;
        ys    <= y;
        ms    <= m;
      end else if (busy) begin
        if (!phase) begin
          acc   <= add_mod(acc, acc, ms);
          phase <= 1'b1;
        end else begin
          if (ys[WIDTH-1]) acc <= add_mod(acc, xs, ms);
          ys    <= ys << 1;
          phase <= 1'b0;
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  assign result = acc;

endmodule

// ----- design/mrpt_datapath.sv -----
module mrpt_datapath (
  input  logic             clk,
  input  logic             rst,
  input  mrpt_pkg::word_t  candidate,
  input  mrpt_pkg::cmd_t   cmd,
  output mrpt_pkg::status_t sts
);
  import mrpt_pkg::*;

  word_t n, d, e, a, b, acc;
  logic [SW-1:0] s, r;
  mm_op_t dst;
  word_t mx, my, mres;
  logic mdone;
  word_t nm1;

  assign nm1 = n - 1'b1;

  always_comb begin
    case (cmd.mm_op)
      MM_RED: begin mx = word_t'(1); my = base_at(cmd.base_idx); end
      MM_MUL: begin mx = acc; my = b; end
      MM_SQB: begin mx = b; my = b; end
      default: begin mx = acc; my = acc; end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mm_start),
    .x      (mx),
    .y      (my),
    .m      (n),
    .done   (mdone),
    .result (mres)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= candidate;
      d <= candidate - 1'b1;
      s <= '0;
    end
    if (cmd.shift_d) begin
      d <= d >> 1;
      s <= s + 1'b1;
    end
    if (cmd.pow_init) begin
      acc <= word_t'(1);
      b   <= a;
      e   <= d;
    end
    if (cmd.e_shift) e <= e >> 1;
    if (cmd.r_init) r <= SW'(1);
    if (cmd.r_inc) r <= r + 1'b1;
    if (cmd.mm_start) dst <= cmd.mm_op;
    if (mdone) begin
      case (dst)
        MM_RED: a <= mres;
        MM_SQB: b <= mres;
        default: acc <= mres;
      endcase
    end
  end

  always_comb begin
    sts.n_lt2     = (n < word_t'(2));
    sts.n_eq2     = (n == word_t'(2));
    sts.n_even    = ~n[0];
    sts.d_odd     = d[0];
    sts.base_eq_n = (base_at(cmd.base_idx) == n);
    sts.a_zero    = (a == '0);
    sts.e_zero    = (e == '0);
    sts.e_lsb     = e[0];
    sts.x_one     = (acc == word_t'(1));
    sts.x_nm1     = (acc == nm1);
    sts.r_lt_s    = (r < s);
    sts.mm_done   = mdone;
  end

endmodule

// ----- design/mrpt_ctrl.sv -----
module mrpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              is_prime,
  input  mrpt_pkg::status_t sts,
  output mrpt_pkg::cmd_t    cmd
);
  import mrpt_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CLASS  = 14'b00000000000010,
    S_FACTOR = 14'b00000000000100,
    S_BASE   = 14'b00000000001000,
    S_RED_W  = 14'b00000000010000,
    S_AZ     = 14'b00000000100000,
    S_POW    = 14'b00000001000000,
    S_MUL_W  = 14'b00000010000000,
    S_SQB_W  = 14'b00000100000000,
    S_CHECK  = 14'b00001000000000,
    S_SQ     = 14'b00010000000000,
    S_SQ_W   = 14'b00100000000000,
    S_SQC    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [KW-1:0] k, k_next;
  logic verdict, verdict_next;
  logic last_base;

  assign in_stall  = (state != S_IDLE);
  assign last_base = (k == KW'(NBASE - 1));

  always_comb begin
    state_next   = state;
    k_next       = k;
    verdict_next = verdict;
    cmd          = '0;
    cmd.base_idx = k;
    cmd.mm_op    = MM_RED;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        k_next = '0;
        if (sts.n_lt2) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else if (sts.n_eq2) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else if (sts.n_even) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          state_next = S_FACTOR;
        end
      end
      S_FACTOR: begin
        if (sts.d_odd) state_next = S_BASE;
        else cmd.shift_d = 1'b1;
      end
      S_BASE: begin
        if (sts.base_eq_n) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_RED;
          state_next   = S_RED_W;
        end
      end
      S_RED_W: begin
        if (sts.mm_done) state_next = S_AZ;
      end
      S_AZ: begin
        if (sts.a_zero) begin
          if (last_base) begin
            verdict_next = 1'b1;
            state_next   = S_DONE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_BASE;
          end
        end else begin
          cmd.pow_init = 1'b1;
          state_next   = S_POW;
        end
      end
      S_POW: begin
        if (sts.e_zero) begin
          state_next = S_CHECK;
        end else if (sts.e_lsb) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_MUL;
          state_next   = S_MUL_W;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_SQB;
          state_next   = S_SQB_W;
        end
      end
      S_MUL_W: begin
        if (sts.mm_done) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_SQB;
          state_next   = S_SQB_W;
        end
      end
      S_SQB_W: begin
        if (sts.mm_done) begin
          cmd.e_shift = 1'b1;
          state_next  = S_POW;
        end
      end
      S_CHECK: begin
        if (sts.x_one || sts.x_nm1) begin
          if (last_base) begin
            verdict_next = 1'b1;
            state_next   = S_DONE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_BASE;
          end
        end else begin
          cmd.r_init = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (sts.r_lt_s) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_SQX;
          state_next   = S_SQ_W;
        end else begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end
      end
      S_SQ_W: begin
        if (sts.mm_done) state_next = S_SQC;
      end
      S_SQC: begin
        if (sts.x_nm1) begin
          if (last_base) begin
            verdict_next = 1'b1;
            state_next   = S_DONE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_BASE;
          end
        end else begin
          cmd.r_inc  = 1'b1;
          state_next = S_SQ;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      verdict   <= 1'b0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      verdict <= verdict_next;
      // hold the result until the downstream transaction completes
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        is_prime  <= verdict;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/miller_rabin_primality_test_core.sv -----
// Deterministic Miller-Rabin test of one 64-bit unsigned candidate per transaction,
// exact for every 64-bit value, using the seven bases 2, 325, 9375, 28178, 450775,
// 9780504 and 1795265022. One candidate is worked on at a time; the result sits in an
// output register, so a new candidate is taken while the previous answer waits.
// The work per candidate is set by the single shared modular multiplier, which forms one
// product at a time: candidates below three and even ones are decided without it, and an
// odd candidate needs a reduction of each base that it tries plus the products of the
// exponentiation and squaring steps for that base.
module miller_rabin_primality_test_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mrpt_pkg::WIDTH-1:0]   candidate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_prime
);
  import mrpt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  mrpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .candidate (candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import mrpt_pkg::*;

  localparam longint CYCLE_LIMIT = 80_000_000;
  localparam int LONG_HOLD = 600;

  localparam word_t WITNESS [7] = '{
    word_t'(2), word_t'(325), word_t'(9375), word_t'(28178),
    word_t'(450775), word_t'(9780504), word_t'(1795265022)
  };

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  word_t candidate;
  logic  out_valid;
  logic  out_stall;
  logic  is_prime;

  bit     primality_q [$];
  int     errors;
  longint cycles;
  bit     no_idle;
  bit     hold_req;

  miller_rabin_primality_test_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic word_t mul_mod_n(input word_t x, input word_t y, input word_t m);
    logic [127:0] p;
    p = {64'b0, x} * {64'b0, y};
    return word_t'(p % {64'b0, m});
  endfunction

  function automatic word_t pow_mod_n(input word_t b, input word_t e, input word_t m);
    word_t acc;
    acc = word_t'(1);
    while (e != 0) begin
      if (e[0]) acc = mul_mod_n(acc, b, m);
      b = mul_mod_n(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_prime(input word_t n);
    word_t d, x, a;
    int    s;
    bit    hit;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int k = 0; k < 7; k++) begin
      if (WITNESS[k] == n) return 1'b1;
      a = WITNESS[k] % n;
      if (a == 0) continue;
      x = pow_mod_n(a, d, n);
      if (x == 1 || x == n - 1) continue;
      hit = 1'b0;
      for (int r = 1; r < s; r++) begin
        x = mul_mod_n(x, x, n);
        if (x == n - 1) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Valid stays high after acceptance until a later call or drain() drives it anew.
  task automatic send_candidate(input word_t n);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    candidate = n;
    do @(posedge clk); while (in_stall);
    primality_q.push_back(predict_prime(n));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (primality_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  always begin
    int wait_cycles;
    bit want;
    @(negedge clk);
    if (hold_req) begin
      out_stall = 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      hold_req = 1'b0;
    end
    wait_cycles = no_idle ? 0 : $urandom_range(0, 12);
    if (wait_cycles > 0) begin
      out_stall = 1'b1;
      repeat (wait_cycles) @(negedge clk);
    end
    out_stall = 1'b0;
    do @(posedge clk); while (out_valid !== 1'b1);
    if (primality_q.size() == 0) begin
      report($sformatf("result %0b with no transaction outstanding", is_prime));
    end else begin
      want = primality_q.pop_front();
      if (is_prime !== want)
        report($sformatf("is_prime %0b, expected %0b", is_prime, want));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** miller_rabin_primality_test_core: FAILED **");
      $finish;
    end
  end

  task automatic test_small_values();
    word_t vals [] = '{0, 1, 2, 3, 4, 5, 9, 15, 561, 2047};
    foreach (vals[i]) send_candidate(vals[i]);
    drain();
  endtask

  // Candidates equal to a witness, or that a witness reduces to zero.
  task automatic test_witnesses();
    foreach (WITNESS[i]) send_candidate(WITNESS[i]);
    send_candidate(word_t'(13));
    drain();
  endtask

  task automatic test_wide_values();
    send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
    send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
    send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
    send_candidate(64'h1FFF_FFFF_FFFF_FFFF);
    send_candidate(word_t'(3215031751));
    send_candidate(word_t'(1000000007));
    send_candidate(64'h8000_0000_0000_0000);
    drain();
  endtask

  // Hold the result side off while quick even candidates keep coming, so the input backs up.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_candidate(word_t'(2 * $urandom_range(0, 20)));
    drain();
  endtask

  task automatic test_random();
    word_t n;
    int    pick;
    for (int i = 0; i < 70; i++) begin
      no_idle = (i >= 40 && i < 55);
      pick = $urandom_range(0, 99);
      if (pick < 25)
        n = {$urandom, $urandom} & ~word_t'(1);
      else if (pick < 75)
        n = word_t'($urandom_range(0, 4095));
      else if (pick < 93)
        n = word_t'($urandom) | word_t'(1);
      else
        n = {$urandom, $urandom};
      send_candidate(n);
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    candidate = '0;
    out_stall = 1'b0;
    errors    = 0;
    cycles    = 0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_small_values();
    test_witnesses();
    test_wide_values();
    test_backpressure();
    test_random();

    if (errors == 0) begin
      $display("** miller_rabin_primality_test_core: PASSED **");
    end else begin
      $display("** miller_rabin_primality_test_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mrpt_pkg.sv
design/mrpt_mulmod.sv
design/mrpt_datapath.sv
design/mrpt_ctrl.sv
design/miller_rabin_primality_test_core.sv
bench/testbench.sv
